/* sv/lobm_pkg.sv */
// lobm_pkg: shared types, codes and defaults of the latency order book matcher
// used by every module of the block but lobm_ram; depends on nothing
`default_nettype none
package lobm_pkg;
	localparam int BOOK_DEPTH_DEF    = 16;
	localparam int PENDING_DEPTH_DEF = 32;

	localparam int IN_DATA_W  = 200;
	localparam int OUT_DATA_W = 88;
	localparam int KIND_W     = 3;
	localparam int ID_W       = 16;
	localparam int PRICE_W    = 32;
	localparam int AMT_W      = 32;
	localparam int TIME_W     = 48;
	localparam int DELAY_W    = 32;

	localparam logic [KIND_W-1:0] KIND_QUOTE        = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CANCEL_BUYS  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CANCEL_SELLS = 3'd2;
	localparam logic [KIND_W-1:0] KIND_TICK         = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR        = 3'd4;

	localparam logic [1:0] EV_NEW    = 2'd0;
	localparam logic [1:0] EV_CANCEL = 2'd1;
	localparam logic [1:0] EV_FILL   = 2'd2;

	localparam logic RES_FILL = 1'b0;
	localparam logic RES_DROP = 1'b1;

	typedef enum logic [1:0] {SCAN_CROSS, SCAN_CANCEL, SCAN_REST, SCAN_EVCAN} scan_mode_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_QUOTE, ST_HEAD, ST_EVAL, ST_EV_FILL,
		ST_SCAN, ST_REST, ST_BEST, ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [AMT_W-1:0]   amount;
		logic [PRICE_W-1:0] price;
		logic               side;
		logic [ID_W-1:0]    id;
		logic [1:0]         event_code;
		logic [TIME_W-1:0]  stamp;
	} pend_t;

	typedef struct packed {
		logic [AMT_W-1:0]   amount;
		logic [PRICE_W-1:0] price;
		logic [ID_W-1:0]    id;
	} book_t;

	typedef struct packed {
		logic               kind;
		logic [ID_W-1:0]    id;
		logic               side;
		logic [PRICE_W-1:0] price;
		logic [AMT_W-1:0]   amount;
	} res_t;

	typedef struct packed {
		logic       load;
		logic       quote_step;
		logic       ev_latch;
		logic       ev_emit;
		logic       pop;
		logic       scan_start;
		logic       new_run;
		scan_mode_t mode;
		logic       side;
		logic       rest_commit;
		logic       best_step;
		logic       flush;
	} cmd_t;

	typedef struct packed {
		logic       fifo_empty;
		logic       ev_matured;
		logic [1:0] ev_event;
		logic       ev_side;
		logic       ev_qual;
		logic       scan_done;
		logic       found;
		logic       emit_ok;
		logic       hold_v;
		logic       out_free;
	} stat_t;
endpackage
`default_nettype wire

/* sv/lobm_ram.sv */
// lobm_ram: generic single write port memory with registered read
// no dependencies
`default_nettype none
module lobm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* sv/lobm_ctrl.sv */
// lobm_ctrl: sequencing state machine of the matcher
// depends on lobm_pkg; drives the datapath through cmd_t, watches stat_t
`default_nettype none
module lobm_ctrl
	import lobm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic [KIND_W-1:0] s_tuser,
	output logic                   s_tready,
	input  wire stat_t             stat,
	output cmd_t                   cmd
);
	state_t     state_q, state_d;
	scan_mode_t mode_q;
	logic       side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= SCAN_CROSS;
			side_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.scan_start) begin
				mode_q <= cmd.mode;
				side_q <= cmd.side;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						KIND_QUOTE: state_d = ST_QUOTE;
						KIND_CANCEL_BUYS, KIND_CANCEL_SELLS: state_d = ST_SCAN;
						KIND_TICK: state_d = ST_HEAD;
						default: state_d = ST_FLUSH;
					endcase
				end
			end
			ST_QUOTE: if (stat.emit_ok) state_d = ST_FLUSH;
			ST_HEAD: state_d = stat.fifo_empty ? ST_SCAN : ST_EVAL;
			ST_EVAL: begin
				if (!stat.ev_matured) begin
					state_d = ST_SCAN;
				end else begin
					case (stat.ev_event)
						EV_NEW: state_d = stat.ev_qual ? ST_SCAN : ST_HEAD;
						EV_CANCEL: state_d = ST_SCAN;
						default: state_d = ST_EV_FILL;
					endcase
				end
			end
			ST_EV_FILL: if (stat.emit_ok) state_d = ST_HEAD;
			ST_SCAN: begin
				if (stat.scan_done) begin
					case (mode_q)
						SCAN_REST: state_d = ST_REST;
						SCAN_EVCAN: state_d = ST_HEAD;
						default: state_d = ST_BEST;
					endcase
				end
			end
			ST_REST: if (stat.emit_ok) state_d = ST_HEAD;
			ST_BEST: begin
				if (!stat.found) begin
					state_d = (mode_q == SCAN_CROSS && !side_q) ? ST_SCAN : ST_FLUSH;
				end else if (stat.emit_ok) begin
					state_d = ST_SCAN;
				end
			end
			ST_FLUSH: if (!stat.hold_v || stat.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.mode = mode_q;
		cmd.side = side_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (s_tuser == KIND_CANCEL_BUYS || s_tuser == KIND_CANCEL_SELLS) begin
						cmd.scan_start = 1'b1;
						cmd.new_run    = 1'b1;
						cmd.mode       = SCAN_CANCEL;
						cmd.side       = (s_tuser == KIND_CANCEL_SELLS);
					end
				end
			end
			ST_QUOTE: cmd.quote_step = stat.emit_ok;
			ST_HEAD: begin
				if (stat.fifo_empty) begin
					cmd.scan_start = 1'b1;
					cmd.new_run    = 1'b1;
					cmd.mode       = SCAN_CROSS;
					cmd.side       = 1'b0;
				end
			end
			ST_EVAL: begin
				cmd.ev_latch = 1'b1;
				if (!stat.ev_matured) begin
					cmd.scan_start = 1'b1;
					cmd.new_run    = 1'b1;
					cmd.mode       = SCAN_CROSS;
					cmd.side       = 1'b0;
				end else begin
					case (stat.ev_event)
						EV_NEW: begin
							if (stat.ev_qual) begin
								cmd.scan_start = 1'b1;
								cmd.mode       = SCAN_REST;
								cmd.side       = stat.ev_side;
							end else begin
								cmd.pop = 1'b1;
							end
						end
						EV_CANCEL: begin
							cmd.scan_start = 1'b1;
							cmd.mode       = SCAN_EVCAN;
							cmd.side       = stat.ev_side;
						end
						default: ;
					endcase
				end
			end
			ST_EV_FILL: begin
				cmd.ev_emit = stat.emit_ok;
				cmd.pop     = stat.emit_ok;
			end
			ST_SCAN: cmd.pop = stat.scan_done && (mode_q == SCAN_EVCAN);
			ST_REST: begin
				cmd.rest_commit = stat.emit_ok;
				cmd.pop         = stat.emit_ok;
			end
			ST_BEST: begin
				if (!stat.found) begin
					if (mode_q == SCAN_CROSS && !side_q) begin
						cmd.scan_start = 1'b1;
						cmd.new_run    = 1'b1;
						cmd.side       = 1'b1;
					end
				end else if (stat.emit_ok) begin
					cmd.best_step  = 1'b1;
					cmd.scan_start = 1'b1;
				end
			end
			ST_FLUSH: cmd.flush = stat.hold_v && stat.out_free;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* sv/lobm_dp.sv */
// lobm_dp: books, pending event fifo, scan unit and result stage
// depends on lobm_pkg and lobm_ram; commanded by lobm_ctrl
`default_nettype none
module lobm_dp
	import lobm_pkg::*;
#(
	parameter int BOOK_DEPTH    = BOOK_DEPTH_DEF,
	parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output stat_t                      stat,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic [KIND_W-1:0]     s_tuser,
	input  wire logic                  cfg_we,
	input  wire logic [DELAY_W-1:0]    cfg_wdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tuser,
	output logic                       m_tlast
);
	localparam int SLOT_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
	localparam int BA_W   = $clog2(2 * BOOK_DEPTH);
	localparam int PA_W   = $clog2(PENDING_DEPTH);
	localparam int CNT_W  = $clog2(PENDING_DEPTH + 1);

	// item and configuration registers
	logic [DELAY_W-1:0] delay_q;
	logic [TIME_W-1:0]  now_q;
	logic [ID_W-1:0]    id_q;
	logic               side_q;
	logic [PRICE_W-1:0] price_q, bid_q, ask_q;
	logic [AMT_W-1:0]   amount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
			now_q   <= '0;
		end else begin
			if (cfg_we) delay_q <= cfg_wdata;
			if (cmd.load && s_tuser == KIND_TICK) now_q <= s_tdata[128:81];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q     <= s_tdata[15:0];
			side_q   <= s_tdata[16];
			price_q  <= s_tdata[48:17];
			amount_q <= s_tdata[80:49];
			bid_q    <= s_tdata[160:129];
			ask_q    <= s_tdata[192:161];
		end
	end

	wire logic clear_all = cmd.load && (s_tuser == KIND_CLEAR);

	// pending fifo
	logic [PA_W-1:0]  head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	pend_t            pend_rd, ev_q, push_data;
	logic             push_req;
	wire logic        fifo_full = (count_q == CNT_W'(PENDING_DEPTH));

	lobm_ram #(.WIDTH($bits(pend_t)), .DEPTH(PENDING_DEPTH)) u_pend_ram (
		.clk(clk), .we(push_req), .waddr(tail_q), .wdata(push_data),
		.raddr(head_q), .rdata(pend_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (clear_all) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (push_req) begin
			tail_q  <= (tail_q == PA_W'(PENDING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			count_q <= count_q + 1'b1;
		end else if (cmd.pop) begin
			head_q  <= (head_q == PA_W'(PENDING_DEPTH - 1)) ? '0 : head_q + 1'b1;
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ev_latch) ev_q <= pend_rd;
	end

	// book store: bids in the lower half, asks in the upper half
	logic [2*BOOK_DEPTH-1:0] valid_q, csent_q;
	logic [SLOT_W-1:0]       cnt_q;
	logic                    run_q, v_s1;
	logic [BA_W-1:0]         addr_s1, rd_addr, best_addr_q, free_addr_q, wr_addr;
	book_t                   book_rd;
	logic                    found_q, free_f_q, have_last_q;
	logic [ID_W-1:0]         best_id_q, last_id_q;
	logic [PRICE_W-1:0]      best_price_q;
	logic [AMT_W-1:0]        best_amount_q;
	logic                    rest_ok;

	assign rd_addr = BA_W'(cnt_q) + (cmd.side ? BA_W'(BOOK_DEPTH) : BA_W'(0));
	assign rest_ok = found_q || free_f_q;
	assign wr_addr = found_q ? best_addr_q : free_addr_q;

	lobm_ram #(.WIDTH($bits(book_t)), .DEPTH(2 * BOOK_DEPTH)) u_book_ram (
		.clk(clk), .we(cmd.rest_commit && rest_ok), .waddr(wr_addr),
		.wdata({ev_q.amount, ev_q.price, ev_q.id}),
		.raddr(rd_addr), .rdata(book_rd)
	);

	wire logic vbit = valid_q[addr_s1];
	wire logic cbit = csent_q[addr_s1];
	wire logic after_last = !have_last_q || (book_rd.id > last_id_q);
	wire logic better = !found_q || (book_rd.id < best_id_q);
	logic cand;

	always_comb begin
		case (cmd.mode)
			SCAN_CROSS: cand = vbit && (cmd.side ? (book_rd.price < bid_q)
				: (book_rd.price > ask_q)) && after_last && better;
			SCAN_CANCEL: cand = vbit && !cbit && after_last && better;
			SCAN_REST: cand = vbit && (book_rd.id == ev_q.id) && !found_q;
			default: cand = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			v_s1        <= 1'b0;
			found_q     <= 1'b0;
			free_f_q    <= 1'b0;
			have_last_q <= 1'b0;
		end else begin
			v_s1 <= run_q;
			if (cmd.scan_start) begin
				run_q    <= 1'b1;
				found_q  <= 1'b0;
				free_f_q <= 1'b0;
				if (cmd.new_run) have_last_q <= 1'b0;
			end else if (run_q && cnt_q == SLOT_W'(BOOK_DEPTH - 1)) begin
				run_q <= 1'b0;
			end
			if (cmd.best_step) have_last_q <= 1'b1;
			if (v_s1 && cand) found_q <= 1'b1;
			if (v_s1 && cmd.mode == SCAN_REST && !vbit && !free_f_q) free_f_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		if (cmd.scan_start) begin
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.best_step) last_id_q <= best_id_q;
		if (v_s1 && cand) begin
			best_addr_q   <= addr_s1;
			best_id_q     <= book_rd.id;
			best_price_q  <= book_rd.price;
			best_amount_q <= book_rd.amount;
		end
		if (v_s1 && cmd.mode == SCAN_REST && !vbit && !free_f_q) free_addr_q <= addr_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			csent_q <= '0;
		end else if (clear_all) begin
			valid_q <= '0;
			csent_q <= '0;
		end else begin
			if (v_s1 && cmd.mode == SCAN_EVCAN && vbit && book_rd.id == ev_q.id) begin
				valid_q[addr_s1] <= 1'b0;
				csent_q[addr_s1] <= 1'b0;
			end
			if (cmd.rest_commit && rest_ok) begin
				valid_q[wr_addr] <= 1'b1;
				csent_q[wr_addr] <= 1'b0;
			end
			if (cmd.best_step && !fifo_full) begin
				if (cmd.mode == SCAN_CROSS) begin
					valid_q[best_addr_q] <= 1'b0;
					csent_q[best_addr_q] <= 1'b0;
				end else begin
					csent_q[best_addr_q] <= 1'b1;
				end
			end
		end
	end

	// pushes and emitted results
	res_t emit_data;
	logic emit_req;

	always_comb begin
		push_req  = 1'b0;
		push_data = '{amount: amount_q, price: price_q, side: side_q, id: id_q,
			event_code: EV_NEW, stamp: now_q};
		emit_req  = 1'b0;
		emit_data = '{kind: RES_DROP, id: id_q, side: side_q, price: price_q,
			amount: amount_q};
		if (cmd.quote_step) begin
			push_req = !fifo_full;
			emit_req = fifo_full;
		end
		if (cmd.best_step) begin
			push_req  = !fifo_full;
			emit_req  = fifo_full;
			push_data = '{amount: best_amount_q, price: best_price_q, side: cmd.side,
				id: best_id_q, event_code: (cmd.mode == SCAN_CROSS) ? EV_FILL : EV_CANCEL,
				stamp: now_q};
			emit_data = '{kind: RES_DROP, id: best_id_q, side: cmd.side,
				price: best_price_q, amount: best_amount_q};
		end
		if (cmd.ev_emit || (cmd.rest_commit && !rest_ok)) begin
			emit_req  = 1'b1;
			emit_data = '{kind: cmd.ev_emit ? RES_FILL : RES_DROP, id: ev_q.id,
				side: ev_q.side, price: ev_q.price, amount: ev_q.amount};
		end
	end

	// the newest result waits in a hold register until it is known whether it is the last
	res_t out_q, hold_q;
	logic out_v_q, hold_v_q, last_q;
	wire logic out_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			hold_v_q <= 1'b0;
		end else begin
			if (m_tready) out_v_q <= 1'b0;
			if (emit_req) begin
				hold_v_q <= 1'b1;
				if (hold_v_q) out_v_q <= 1'b1;
			end
			if (cmd.flush) begin
				hold_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_req) begin
			hold_q <= emit_data;
			if (hold_v_q) begin
				out_q  <= hold_q;
				last_q <= 1'b0;
			end
		end
		if (cmd.flush) begin
			out_q  <= hold_q;
			last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = last_q;
	assign m_tdata  = {7'd0, out_q.amount, out_q.price, out_q.side, out_q.id};

	always_comb begin
		stat.fifo_empty = (count_q == '0);
		stat.ev_matured = {1'b0, now_q} >= ({1'b0, pend_rd.stamp} + (TIME_W + 1)'(delay_q));
		stat.ev_event   = pend_rd.event_code;
		stat.ev_side    = pend_rd.side;
		stat.ev_qual    = pend_rd.side ? (pend_rd.price > bid_q) : (pend_rd.price <= ask_q);
		stat.scan_done  = !run_q && !v_s1;
		stat.found      = found_q;
		stat.emit_ok    = !hold_v_q || out_free;
		stat.hold_v     = hold_v_q;
		stat.out_free   = out_free;
	end
endmodule
`default_nettype wire

/* sv/latency_order_book_matcher.sv */
// sequence: a quote is pushed to the fifo or dropped, then flushed; clear or an unused kind
// is only flushed; one book scan pass reads the book memory one entry per cycle
// cancel-all: one pass per order picked plus a closing pass, then the flush
// tick: each matured fifo head is handled in turn (fill, cancel with a pass, new with a pass
// and a rest if it qualifies) until the fifo is empty or its head unmatured, then per side
// one pass per order filled plus a closing pass, then the flush; a stalled m_tready delays it
// throughput: one transaction in flight; the next is taken once the previous has finished
// reset: arst_n asynchronous, active low, empties books and fifo and zeroes time and delay
`default_nettype none
module latency_order_book_matcher
	import lobm_pkg::*;
#(
	parameter int BOOK_DEPTH    = BOOK_DEPTH_DEF,
	parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input channel
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// id[15:0], side[16], price[48:17], amount[80:49], market_time[128:81],
	// best_bid[160:129], best_ask[192:161], zero fill above
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// kind[2:0]
	input  wire logic [KIND_W-1:0]     s_tuser,
	// delay register write
	input  wire logic                  cfg_we,
	input  wire logic [DELAY_W-1:0]    cfg_wdata,
	// result channel
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// res_id[15:0], side_res[16], price_res[48:17], amount_res[80:49], zero fill above
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// result_kind[0]
	output logic                       m_tuser,
	// last result of one input transaction
	output logic                       m_tlast
);
	cmd_t  cmd;
	stat_t stat;

	// controller sequences fifo walk, book scans and result flush
	lobm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tuser(s_tuser),
		.s_tready(s_tready), .stat(stat), .cmd(cmd)
	);

	// datapath holds the books, pending fifo and output staging
	lobm_dp #(.BOOK_DEPTH(BOOK_DEPTH), .PENDING_DEPTH(PENDING_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);
endmodule
`default_nettype wire

/* sv/lobm_chk.sv */
// lobm_chk: port level checks of the matcher, bound to the top level
// depends on lobm_pkg and latency_order_book_matcher
`default_nettype none
module lobm_chk
	import lobm_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic                  m_tuser,
	input wire logic                  m_tlast
);
	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// one transaction at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// a result still waiting when idle closes its transaction
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && m_tvalid |-> m_tlast)
		else $error("idle with an unfinished result run");
endmodule

bind latency_order_book_matcher lobm_chk u_lobm_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
	.m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire

/* verif/tb_latency_order_book_matcher.sv */
// tb_latency_order_book_matcher: self-checking testbench of the latency order book matcher
// depends on lobm_pkg and latency_order_book_matcher; a built-in exchange predictor checks each result
`default_nettype none
module tb_latency_order_book_matcher;
	import lobm_pkg::*;

	localparam int BD = BOOK_DEPTH_DEF;
	localparam int PD = PENDING_DEPTH_DEF;
	localparam int STALL_LIMIT = 200000;

	// one result of the exchange as the checker sees it
	typedef struct {
		logic               kind;
		logic [ID_W-1:0]    id;
		logic               side;
		logic [PRICE_W-1:0] price;
		logic [AMT_W-1:0]   amount;
		logic               last;
	} fill_rec_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic [KIND_W-1:0] s_tuser;
	logic cfg_we;
	logic [DELAY_W-1:0] cfg_wdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	latency_order_book_matcher DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// predictor state: bids in slots 0..BD-1, asks above
	logic               bk_valid [2*BD];
	logic               bk_cxl   [2*BD];
	logic [ID_W-1:0]    bk_id    [2*BD];
	logic [PRICE_W-1:0] bk_price [2*BD];
	logic [AMT_W-1:0]   bk_amt   [2*BD];
	logic [TIME_W-1:0]  pq_stamp [PD];
	logic [1:0]         pq_ev    [PD];
	logic [ID_W-1:0]    pq_id    [PD];
	logic               pq_side  [PD];
	logic [PRICE_W-1:0] pq_price [PD];
	logic [AMT_W-1:0]   pq_amt   [PD];
	int                 pq_head, pq_count;
	logic [TIME_W-1:0]  now_time;
	logic [DELAY_W-1:0] delay_reg;

	fill_rec_t expected_fills[$];
	fill_rec_t step_out[$];
	int  errors = 0;
	int  idle_cycles = 0;
	bit  calm = 0;          // no idling on either side while set
	logic [TIME_W-1:0] mkt_time = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// ---------------- predictor ----------------
	function automatic void book_clear();
		for (int i = 0; i < 2*BD; i++) begin
			bk_valid[i] = 0;
			bk_cxl[i] = 0;
		end
		pq_head = 0;
		pq_count = 0;
	endfunction

	function automatic void note(logic k, logic [ID_W-1:0] id, logic sd, logic [PRICE_W-1:0] p,
			logic [AMT_W-1:0] a);
		fill_rec_t r;
		r.kind = k; r.id = id; r.side = sd; r.price = p; r.amount = a; r.last = 0;
		step_out.insert(step_out.size(), r);
	endfunction

	function automatic bit enqueue(logic [1:0] ev, logic [ID_W-1:0] id, logic sd,
			logic [PRICE_W-1:0] p, logic [AMT_W-1:0] a);
		int ix;
		if (pq_count >= PD) return 0;
		ix = (pq_head + pq_count) % PD;
		pq_stamp[ix] = now_time; pq_ev[ix] = ev; pq_id[ix] = id; pq_side[ix] = sd;
		pq_price[ix] = p; pq_amt[ix] = a;
		pq_count++;
		return 1;
	endfunction

	// lowest-id slot qualifying for a cancel (cancel_mode) or a cross, id above floor
	function automatic int pick_slot(logic sd, bit cancel_mode, bit have_floor,
			logic [ID_W-1:0] floor_id, logic [PRICE_W-1:0] bid, logic [PRICE_W-1:0] ask);
		int best;
		int i;
		bit ok;
		best = -1;
		for (int s = 0; s < BD; s++) begin
			i = sd * BD + s;
			if (!bk_valid[i]) continue;
			if (cancel_mode) ok = !bk_cxl[i];
			else if (sd == 0) ok = bk_price[i] > ask;
			else ok = bk_price[i] < bid;
			if (!ok) continue;
			if (have_floor && bk_id[i] <= floor_id) continue;
			if (best < 0 || bk_id[i] < bk_id[best]) best = i;
		end
		return best;
	endfunction

	function automatic void scan_side(logic sd, bit cancel_mode, logic [PRICE_W-1:0] bid,
			logic [PRICE_W-1:0] ask);
		bit have_floor;
		logic [ID_W-1:0] floor_id;
		int i;
		have_floor = 0;
		floor_id = 0;
		forever begin
			i = pick_slot(sd, cancel_mode, have_floor, floor_id, bid, ask);
			if (i < 0) break;
			have_floor = 1;
			floor_id = bk_id[i];
			if (enqueue(cancel_mode ? EV_CANCEL : EV_FILL, bk_id[i], sd, bk_price[i], bk_amt[i]))
			begin
				if (cancel_mode) bk_cxl[i] = 1;
				else begin
					bk_valid[i] = 0;
					bk_cxl[i] = 0;
				end
			end else
				note(RES_DROP, bk_id[i], sd, bk_price[i], bk_amt[i]);
		end
	endfunction

	function automatic void rest_new(int ix);
		int slot;
		int i;
		slot = -1;
		for (int s = 0; s < BD && slot < 0; s++) begin
			i = pq_side[ix] * BD + s;
			if (bk_valid[i] && bk_id[i] == pq_id[ix]) slot = i;
		end
		for (int s = 0; s < BD && slot < 0; s++) begin
			i = pq_side[ix] * BD + s;
			if (!bk_valid[i]) slot = i;
		end
		if (slot < 0) begin
			note(RES_DROP, pq_id[ix], pq_side[ix], pq_price[ix], pq_amt[ix]);
			return;
		end
		bk_valid[slot] = 1; bk_cxl[slot] = 0; bk_id[slot] = pq_id[ix];
		bk_price[slot] = pq_price[ix]; bk_amt[slot] = pq_amt[ix];
	endfunction

	function automatic void market_tick(logic [TIME_W-1:0] t, logic [PRICE_W-1:0] bid,
			logic [PRICE_W-1:0] ask);
		int ix;
		int i;
		now_time = t;
		while (pq_count > 0) begin
			ix = pq_head;
			// 49 bits so that stamp plus delay cannot wrap
			if ({1'b0, t} < {1'b0, pq_stamp[ix]} + 49'(delay_reg)) break;
			if (pq_ev[ix] == EV_NEW) begin
				if ((pq_side[ix] == 0 && pq_price[ix] <= ask) ||
						(pq_side[ix] == 1 && pq_price[ix] > bid))
					rest_new(ix);
			end else if (pq_ev[ix] == EV_CANCEL) begin
				for (int s = 0; s < BD; s++) begin
					i = pq_side[ix] * BD + s;
					if (bk_valid[i] && bk_id[i] == pq_id[ix]) begin
						bk_valid[i] = 0;
						bk_cxl[i] = 0;
					end
				end
			end else
				note(RES_FILL, pq_id[ix], pq_side[ix], pq_price[ix], pq_amt[ix]);
			pq_head = (pq_head + 1) % PD;
			pq_count--;
		end
		scan_side(0, 0, bid, ask);
		scan_side(1, 0, bid, ask);
	endfunction

	// works out the results of one input transaction and queues them
	function automatic void predict_exchange(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
			logic sd, logic [PRICE_W-1:0] p, logic [AMT_W-1:0] a, logic [TIME_W-1:0] t,
			logic [PRICE_W-1:0] bid, logic [PRICE_W-1:0] ask);
		step_out.delete();
		case (kind)
			KIND_QUOTE: begin
				if (!enqueue(EV_NEW, id, sd, p, a)) note(RES_DROP, id, sd, p, a);
			end
			KIND_CANCEL_BUYS: scan_side(0, 1, 0, 0);
			KIND_CANCEL_SELLS: scan_side(1, 1, 0, 0);
			KIND_TICK: market_tick(t, bid, ask);
			KIND_CLEAR: book_clear();
			default: ;
		endcase
		if (step_out.size() > 0) step_out[step_out.size()-1].last = 1;
		foreach (step_out[k]) expected_fills.insert(expected_fills.size(), step_out[k]);
	endfunction

	// ---------------- driving ----------------
	task automatic send_item(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id, logic sd,
			logic [PRICE_W-1:0] p, logic [AMT_W-1:0] a, logic [TIME_W-1:0] t,
			logic [PRICE_W-1:0] bid, logic [PRICE_W-1:0] ask);
		while (!calm && $urandom_range(99) < 6) @(posedge clk);
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= {7'b0, ask, bid, t, a, p, sd, id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_exchange(kind, id, sd, p, a, t, bid, ask);
		s_tvalid <= 0;
		// the block stays busy for at least this cycle
		@(posedge clk);
	endtask

	task automatic quote(logic [ID_W-1:0] id, logic sd, logic [PRICE_W-1:0] p,
			logic [AMT_W-1:0] a);
		send_item(KIND_QUOTE, id, sd, p, a, 0, 0, 0);
	endtask

	task automatic tick_at(logic [TIME_W-1:0] t, logic [PRICE_W-1:0] bid,
			logic [PRICE_W-1:0] ask);
		send_item(KIND_TICK, 0, 0, 0, 0, t, bid, ask);
	endtask

	// waits for every result and for the block to be idle again
	task automatic drain();
		while (expected_fills.size() > 0 || !s_tready) @(posedge clk);
	endtask

	task automatic write_delay(logic [DELAY_W-1:0] d);
		drain();
		cfg_we <= 1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 0;
		delay_reg = d;
	endtask

	// ---------------- result checking ----------------
	always @(posedge clk) begin
		if (!arst_n) m_tready <= 0;
		else if (!calm) m_tready <= ($urandom_range(99) >= 6);
		else m_tready <= 1;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (m_tvalid && m_tready) begin
			if (expected_fills.size() == 0) begin
				$display("%0t: unexpected result kind %0b data %h last %0b", $time, m_tuser,
					m_tdata, m_tlast);
				errors++;
			end else begin
				fill_rec_t e;
				e = expected_fills.pop_front();
				if (m_tuser !== e.kind || m_tdata[15:0] !== e.id || m_tdata[16] !== e.side ||
						m_tdata[48:17] !== e.price || m_tdata[80:49] !== e.amount ||
						m_tlast !== e.last) begin
					$display("%0t: mismatch expected kind %0b id %h side %0b price %h amt %h last %0b",
						$time, e.kind, e.id, e.side, e.price, e.amount, e.last);
					$display("%0t:          actual kind %0b id %h side %0b price %h amt %h last %0b",
						$time, m_tuser, m_tdata[15:0], m_tdata[16], m_tdata[48:17],
						m_tdata[80:49], m_tlast);
					errors++;
				end
			end
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
				expected_fills.size());
			$display("** latency_order_book_matcher: FAILED **");
			$finish;
		end
	end

	// ---------------- test tasks ----------------
	// field extremes, cancel-all on both sides, fills and rests
	task automatic test_directed();
		quote(16'h0000, 0, 32'd100, 32'h0000_0000);
		quote(16'hFFFF, 1, 32'd90, 32'hFFFF_FFFF);
		quote(16'h0005, 0, 32'hFFFF_FFFF, 32'h1234_5678);
		quote(16'h0006, 1, 32'h0000_0000, 32'h8765_4321);
		tick_at(48'd1, 32'd50, 32'd200);       // rests buys at or below ask and sells above bid
		tick_at(48'd2, 32'd95, 32'd95);        // bid 100 crosses ask, ask 90 crosses bid
		tick_at(48'd3, 32'd95, 32'd95);        // fills mature
		quote(16'h0007, 0, 32'd10, 32'd7);
		quote(16'h0007, 0, 32'd11, 32'd8);     // same id overwrites
		quote(16'h0008, 1, 32'd300, 32'd9);
		quote(16'h0009, 0, 32'd500, 32'd1);    // above ask, never rests
		tick_at(48'd4, 32'd20, 32'd400);
		send_item(KIND_CANCEL_BUYS, 0, 0, 0, 0, 0, 0, 0);
		send_item(KIND_CANCEL_BUYS, 0, 0, 0, 0, 0, 0, 0);  // already sent, skipped
		send_item(KIND_CANCEL_SELLS, 0, 0, 0, 0, 0, 0, 0);
		send_item(3'd7, 16'hFFFF, 1, '1, '1, '1, '1, '1);  // unused kind
		tick_at(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
		tick_at(48'd10, 32'd0, 32'hFFFF_FFFF);     // time going back
		send_item(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		mkt_time = 10;
	endtask

	// fill the pending fifo and the book to force drops
	task automatic test_full_stores();
		for (int i = 0; i < PD + 3; i++) quote(16'(i), 1, 32'd1000, 32'(i));
		tick_at(mkt_time, 32'd0, 32'd0);        // asks rest until book full, rest dropped
		for (int i = 0; i < PD - 1; i++) quote(16'(100 + i), 0, 32'd1, 32'd0);
		send_item(KIND_CANCEL_SELLS, 0, 0, 0, 0, 0, 0, 0);  // fifo overflows mid scan
		tick_at(mkt_time, 32'd2000, 32'd5);     // asks cross and fill
		send_item(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
	endtask

	task automatic random_item();
		int r;
		logic [PRICE_W-1:0] mid;
		r = $urandom_range(99);
		mid = 32'd1000 + $urandom_range(20);
		if (r < 55) begin
			if ($urandom_range(9) == 0)
				quote(16'($urandom), 1'($urandom_range(1)), $urandom, $urandom);
			else
				quote(16'($urandom_range(40)), 1'($urandom_range(1)),
					32'd990 + $urandom_range(40), $urandom);
		end else if (r < 85) begin
			if ($urandom_range(19) != 0) mkt_time = mkt_time + 48'($urandom_range(3));
			else mkt_time = 48'({$urandom, $urandom});
			if ($urandom_range(9) == 0)
				tick_at(mkt_time, $urandom, $urandom);
			else
				tick_at(mkt_time, mid - $urandom_range(10), mid + $urandom_range(10));
		end else if (r < 92)
			send_item(3'($urandom_range(1, 2)), 16'($urandom), 1'($urandom_range(1)),
				$urandom, $urandom, 48'({$urandom, $urandom}), $urandom, $urandom);
		else if (r < 95)
			send_item(KIND_CLEAR, 16'($urandom), 1'($urandom_range(1)), $urandom, $urandom,
				48'({$urandom, $urandom}), $urandom, $urandom);
		else
			send_item(3'($urandom_range(5, 7)), 16'($urandom), 1'($urandom_range(1)),
				$urandom, $urandom, 48'({$urandom, $urandom}), $urandom, $urandom);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			calm = (i >= n / 3 && i < n / 2);   // stretch with no idling
			random_item();
		end
		calm = 0;
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = KIND_QUOTE;
		cfg_we = 0;
		cfg_wdata = '0;
		delay_reg = 0;
		now_time = 0;
		book_clear();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		test_directed();
		test_full_stores();
		write_delay(32'd0);
		test_random(150);
		write_delay(32'd2);
		test_random(150);
		drain();                               // sender waits for every result
		write_delay(32'hFFFF_FFFF);
		test_random(80);
		send_item(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		write_delay(32'd1);
		test_random(120);

		drain();
		if (errors == 0 && expected_fills.size() == 0)
			$display("** latency_order_book_matcher: PASSED **");
		else
			$display("** latency_order_book_matcher: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
